// ===== src/brme_pkg.sv =====
// shared types, opcodes and the minifloat encoder for the byte register machine executor
package brme_pkg;

    localparam int NUM_REGS  = 16;
    localparam int MEM_BYTES = 256;
    localparam int REG_AW    = $clog2(NUM_REGS);
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    localparam logic [3:0] OP_LOAD_MEM = 4'h1;
    localparam logic [3:0] OP_LOAD_IMM = 4'h2;
    localparam logic [3:0] OP_STORE    = 4'h3;
    localparam logic [3:0] OP_MOVE     = 4'h4;
    localparam logic [3:0] OP_ADD      = 4'h5;
    localparam logic [3:0] OP_SUB_FLT  = 4'h6;
    localparam logic [3:0] OP_JUMP_EQ  = 4'hB;
    localparam logic [3:0] OP_HALT     = 4'hC;

    localparam logic [1:0] ST_EXEC    = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [15:0] word;
        logic [7:0]  opa;
        logic [7:0]  opb;
        logic [7:0]  r0;
        logic [7:0]  mem;
        logic [7:0]  pc;
    } t_operands;

    typedef struct packed {
        logic [1:0] status;
        logic       taken;
        logic [7:0] pc;
        logic [7:0] value;
        logic       wreg;
        logic       wmem;
    } t_result;

    // sign, exponent clamped at 7, four bits below the leading one
    function automatic logic [7:0] to_minifloat(input logic [7:0] s, input logic [7:0] t);
        logic        neg;
        logic [7:0]  a;
        logic [2:0]  e;
        logic [2:0]  ex;
        logic [11:0] sh;
        neg = (s < t);
        a   = neg ? (t - s) : (s - t);
        e   = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (a[i]) begin
                e = 3'(i);
            end
        end
        ex = (e > 3'd4) ? 3'd7 : (e + 3'd3);
        sh = {a, 4'b0000} >> e;
        return (a == 8'd0) ? 8'd0 : {neg, ex, sh[3:0]};
    endfunction

endpackage

// ===== src/byte_register_machine_executor_core.sv =====
// top level: operand read stage, execute, result register and architectural state
// an accepted word is held in the operand read register, executed, and its result captured in the result register
// throughput: one instruction word per cycle while the output is not stalled, set by the single execute stage
// operands are read at accept and bypassed from the result register on a hit
// reset clears registers, counter and the data memory valid bits at once; no clearing pass
module byte_register_machine_executor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_instruction_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_branch_taken,
    output logic [7:0]  o_program_counter,
    output logic [7:0]  o_written_value,
    output logic        o_wrote_register,
    output logic        o_wrote_memory
);
    import brme_pkg::*;

    logic        r_v1;
    logic [15:0] r_word1;
    logic [7:0]  r_rd_a;
    logic [7:0]  r_rd_b;
    logic [7:0]  r_rd_0;
    logic        r_fwd_a;
    logic        r_fwd_b;
    logic        r_fwd_0;
    logic        r_fwd_m;
    logic [7:0]  r_rf [NUM_REGS];
    logic [7:0]  r_pc;
    logic        r_v2;
    t_result     r_out;

    logic              w_acc;
    logic              w_adv1;
    logic [3:0]        w_in_op;
    logic [REG_AW-1:0] w_in_r;
    logic [REG_AW-1:0] w_addr_a;
    logic [REG_AW-1:0] w_addr_b;
    logic [MEM_AW-1:0] w_in_xy;
    logic [REG_AW-1:0] w_r1_r;
    logic [MEM_AW-1:0] w_r1_xy;
    logic [7:0]        w_mem_rd;
    t_operands         w_ops;
    t_result           w_res;

    assign w_adv1  = r_v1 && (!r_v2 || !i_stall);
    assign o_stall = r_v1 && !w_adv1;
    assign w_acc   = i_valid && !o_stall;

    assign w_in_op  = i_instruction_word[15:12];
    assign w_in_r   = i_instruction_word[11:8];
    assign w_in_xy  = i_instruction_word[7:0];
    assign w_addr_a = (w_in_op == OP_STORE || w_in_op == OP_JUMP_EQ) ?
                      w_in_r : i_instruction_word[7:4];
    assign w_addr_b = i_instruction_word[3:0];
    assign w_r1_r   = r_word1[11:8];
    assign w_r1_xy  = r_word1[7:0];

    brme_dmem u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_acc),
        .i_rd_addr (w_in_xy),
        .o_rd_data (w_mem_rd),
        .i_wr_en   (w_adv1 && w_res.wmem),
        .i_wr_addr (w_r1_xy),
        .i_wr_data (w_res.value)
    );

    // operand read; a hit on the word committing at this edge is bypassed later
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_word1 <= i_instruction_word;
            r_rd_a  <= r_rf[w_addr_a];
            r_rd_b  <= r_rf[w_addr_b];
            r_rd_0  <= r_rf[0];
            r_fwd_a <= w_adv1 && w_res.wreg && (w_r1_r == w_addr_a);
            r_fwd_b <= w_adv1 && w_res.wreg && (w_r1_r == w_addr_b);
            r_fwd_0 <= w_adv1 && w_res.wreg && (w_r1_r == '0);
            r_fwd_m <= w_adv1 && w_res.wmem && (w_r1_xy == w_in_xy);
        end
    end

    assign w_ops.word = r_word1;
    assign w_ops.opa  = r_fwd_a ? r_out.value : r_rd_a;
    assign w_ops.opb  = r_fwd_b ? r_out.value : r_rd_b;
    assign w_ops.r0   = r_fwd_0 ? r_out.value : r_rd_0;
    assign w_ops.mem  = r_fwd_m ? r_out.value : w_mem_rd;
    assign w_ops.pc   = r_pc;

    brme_alu u_alu (
        .i_ops (w_ops),
        .o_res (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_rf[i] <= 8'd0;
            end
        end else if (w_adv1 && w_res.wreg) begin
            r_rf[w_r1_r] <= w_res.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_pc <= 8'd0;
        end else begin
            r_v1 <= w_acc || (r_v1 && !w_adv1);
            r_v2 <= w_adv1 || (r_v2 && i_stall);
            if (w_adv1) begin
                r_pc <= w_res.pc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_out <= w_res;
        end
    end

    assign o_valid           = r_v2;
    assign o_status          = r_out.status;
    assign o_branch_taken    = r_out.taken;
    assign o_program_counter = r_out.pc;
    assign o_written_value   = r_out.value;
    assign o_wrote_register  = r_out.wreg;
    assign o_wrote_memory    = r_out.wmem;

    a_pc_only_on_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_pc != $past(r_pc)) |-> $past(w_adv1 && w_res.taken))
        else $error("program counter changed without a taken branch");

    a_pc_matches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_program_counter == r_pc))
        else $error("result counter differs from architectural counter");

    a_no_write_unless_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_EXEC) |->
        (!o_wrote_register && !o_wrote_memory && o_written_value == 8'd0))
        else $error("halt or unknown word reported a write");

endmodule

// ===== src/brme_alu.sv =====
// instruction decode and execute logic between operand and result registers
module brme_alu (
    input  brme_pkg::t_operands i_ops,
    output brme_pkg::t_result   o_res
);
    import brme_pkg::*;

    logic [3:0] w_op;
    logic [7:0] w_xy;

    assign w_op = i_ops.word[15:12];
    assign w_xy = i_ops.word[7:0];

    always_comb begin
        o_res        = '0;
        o_res.pc     = i_ops.pc;
        o_res.status = ST_EXEC;
        unique case (w_op)
            OP_LOAD_MEM: begin
                o_res.value = i_ops.mem;
                o_res.wreg  = 1'b1;
            end
            OP_LOAD_IMM: begin
                o_res.value = w_xy;
                o_res.wreg  = 1'b1;
            end
            OP_STORE: begin
                o_res.value = i_ops.opa;
                o_res.wmem  = 1'b1;
            end
            OP_MOVE: begin
                o_res.value = i_ops.opa;
                o_res.wreg  = 1'b1;
            end
            OP_ADD: begin
                o_res.value = i_ops.opa + i_ops.opb;
                o_res.wreg  = 1'b1;
            end
            OP_SUB_FLT: begin
                o_res.value = to_minifloat(i_ops.opa, i_ops.opb);
                o_res.wreg  = 1'b1;
            end
            OP_JUMP_EQ: begin
                if (i_ops.opa == i_ops.r0) begin
                    o_res.pc    = w_xy;
                    o_res.taken = 1'b1;
                end
            end
            OP_HALT: begin
                o_res.status = ST_HALT;
            end
            default: begin
                o_res.status = ST_UNKNOWN;
            end
        endcase
    end

endmodule

// ===== src/brme_dmem.sv =====
// 256-byte data memory with per-byte valid bits and registered read
module brme_dmem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [brme_pkg::MEM_AW-1:0] i_rd_addr,
    output logic [7:0]                  o_rd_data,
    input  logic                        i_wr_en,
    input  logic [brme_pkg::MEM_AW-1:0] i_wr_addr,
    input  logic [7:0]                  i_wr_data
);
    import brme_pkg::*;

    logic [7:0]           r_mem [MEM_BYTES];
    logic [MEM_BYTES-1:0] r_vld;
    logic [7:0]           r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
        end
    end

    // bytes never written since reset read as zero
    assign o_rd_data = r_rd_vld ? r_rd_data : 8'd0;

endmodule
